[sv/dda_line_generator_defines.svh]
// Assertion macros shared by the checker of the DDA line generator.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef DDA_LINE_GENERATOR_DEFINES_SVH
`define DDA_LINE_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define DDA_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("dda assertion failed");

// Next-cycle implication, disabled while in reset.
`define DDA_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("dda assertion failed");

`endif

[sv/dda_pkg.sv]
// Shared types, widths and helpers of the DDA line generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package dda_pkg;

  localparam int COORD_BITS  = 12;
  localparam int FRAC_BITS   = 16;
  localparam int POS_BITS    = COORD_BITS + FRAC_BITS;
  localparam int STEP_BITS   = FRAC_BITS + 2;
  localparam int QUO_BITS    = FRAC_BITS + 1;
  localparam int LEFT_BITS   = COORD_BITS + 1;
  localparam int REM_BITS    = COORD_BITS + 1;
  localparam int CNT_BITS    = $clog2(QUO_BITS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  typedef struct packed {
    logic                         mode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         last_pixel;
  } out_item_t;

  // Classified command passed from front to back.
  typedef struct packed {
    logic                         op;
    logic signed [COORD_BITS-1:0] org_x;
    logic signed [COORD_BITS-1:0] org_y;
    logic        [COORD_BITS-1:0] mag_x;
    logic        [COORD_BITS-1:0] mag_y;
    logic        [COORD_BITS-1:0] steps;
    logic                         neg_x;
    logic                         neg_y;
  } cmd_t;

  typedef struct packed {
    logic                  start;
    logic [COORD_BITS-1:0] mag_x;
    logic [COORD_BITS-1:0] mag_y;
    logic [COORD_BITS-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [QUO_BITS-1:0] quo_x;
    logic [QUO_BITS-1:0] quo_y;
  } div_rsp_t;

  // Integer part of a fixed-point position, truncated toward zero.
  function automatic logic [COORD_BITS-1:0] pixel_of(input logic signed [POS_BITS-1:0] pos);
    logic [COORD_BITS-1:0] whole;
    whole = pos[POS_BITS-1:FRAC_BITS];
    if (pos[POS_BITS-1] && (|pos[FRAC_BITS-1:0])) begin
      whole = whole + 1'b1;
    end
    return whole;
  endfunction

endpackage
`default_nettype wire

[sv/dda_front.sv]
// Front end: accepts input transactions and classifies them into commands.
// Depends on dda_pkg; feeds dda_queue.
`timescale 1ns / 1ps
`default_nettype none
module dda_front (
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dda_pkg::in_item_t in_item_i,
  input  logic           full_i,
  output logic           push_o,
  output dda_pkg::cmd_t  cmd_o
);
  import dda_pkg::*;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic signed [COORD_BITS:0] ndx;
  logic signed [COORD_BITS:0] ndy;
  logic [COORD_BITS-1:0]      mag_x;
  logic [COORD_BITS-1:0]      mag_y;

  always_comb begin
    dx  = {in_item_i.end_x[COORD_BITS-1], in_item_i.end_x}
        - {in_item_i.start_x[COORD_BITS-1], in_item_i.start_x};
    dy  = {in_item_i.end_y[COORD_BITS-1], in_item_i.end_y}
        - {in_item_i.start_y[COORD_BITS-1], in_item_i.start_y};
    ndx = -dx;
    ndy = -dy;
    mag_x = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    mag_y = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

    cmd_o.op    = (in_item_i.mode == OP_NEXT) ? OP_NEXT : OP_START;
    cmd_o.org_x = in_item_i.start_x;
    cmd_o.org_y = in_item_i.start_y;
    cmd_o.mag_x = mag_x;
    cmd_o.mag_y = mag_y;
    cmd_o.steps = (mag_x > mag_y) ? mag_x : mag_y;
    cmd_o.neg_x = dx[COORD_BITS];
    cmd_o.neg_y = dy[COORD_BITS];
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule
`default_nettype wire

[sv/dda_queue.sv]
// Short command queue decoupling the front end from the back end.
// Depends on dda_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dda_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dda_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output dda_pkg::cmd_t data_o
);
  import dda_pkg::*;

  cmd_t                 mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

[sv/dda_div.sv]
// Restoring divider: both magnitudes scaled by 2^FRAC_BITS over one shared divisor.
// Depends on dda_pkg; one quotient bit per axis per cycle.
`timescale 1ns / 1ps
`default_nettype none
module dda_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dda_pkg::div_req_t req_i,
  output dda_pkg::div_rsp_t rsp_o
);
  import dda_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic                  first_q, first_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [COORD_BITS-1:0] dvs_q, dvs_d;
  logic [REM_BITS-1:0]   rx_q, rx_d, ry_q, ry_d;
  logic [QUO_BITS-1:0]   qx_q, qx_d, qy_q, qy_d;
  logic [REM_BITS-1:0]   shx, shy, dvs_ext;
  logic                  gex, gey;

  always_comb begin
    // The magnitude never exceeds the divisor, so the first trial needs no shift.
    shx     = first_q ? rx_q : {rx_q[REM_BITS-2:0], 1'b0};
    shy     = first_q ? ry_q : {ry_q[REM_BITS-2:0], 1'b0};
    dvs_ext = {1'b0, dvs_q};
    gex     = shx >= dvs_ext;
    gey     = shy >= dvs_ext;

    busy_d  = busy_q;
    done_d  = 1'b0;
    first_d = first_q;
    cnt_d   = cnt_q;
    dvs_d   = dvs_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    qx_d    = qx_q;
    qy_d    = qy_q;

    if (req_i.start) begin
      busy_d  = 1'b1;
      first_d = 1'b1;
      cnt_d   = CNT_BITS'(QUO_BITS);
      dvs_d   = req_i.steps;
      rx_d    = {1'b0, req_i.mag_x};
      ry_d    = {1'b0, req_i.mag_y};
      qx_d    = '0;
      qy_d    = '0;
    end else if (busy_q) begin
      first_d = 1'b0;
      rx_d    = gex ? shx - dvs_ext : shx;
      ry_d    = gey ? shy - dvs_ext : shy;
      qx_d    = {qx_q[QUO_BITS-2:0], gex};
      qy_d    = {qy_q[QUO_BITS-2:0], gey};
      cnt_d   = cnt_q - 1'b1;
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    cnt_q   <= cnt_d;
    dvs_q   <= dvs_d;
    rx_q    <= rx_d;
    ry_q    <= ry_d;
    qx_q    <= qx_d;
    qy_q    <= qy_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.quo_x = qx_q;
  assign rsp_o.quo_y = qy_q;

endmodule
`default_nettype wire

[sv/dda_back.sv]
// Back end: runs commands, holds the line state and the output register.
// Depends on dda_pkg; drives dda_div for the increment computation.
`timescale 1ns / 1ps
`default_nettype none
module dda_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  dda_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output dda_pkg::div_req_t  div_req_o,
  input  dda_pkg::div_rsp_t  div_rsp_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dda_pkg::out_item_t out_item_o
);
  import dda_pkg::*;

  localparam logic ST_RUN = 1'b0;
  localparam logic ST_DIV = 1'b1;

  logic                        state_q, state_d;
  logic                        active_q, active_d;
  logic                        out_valid_q, out_valid_d;
  out_item_t                   out_q, out_d;
  logic signed [POS_BITS-1:0]  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [STEP_BITS-1:0] step_x_q, step_x_d, step_y_q, step_y_d;
  logic [LEFT_BITS-1:0]        left_q, left_d;
  logic                        neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic signed [POS_BITS-1:0]  sum_x, sum_y;
  logic [STEP_BITS-1:0]        ux, uy;
  logic                        slot_free;
  logic                        pop;

  always_comb begin
    slot_free = !out_valid_q || !out_stall_i;
    pop       = cmd_valid_i && (state_q == ST_RUN) && slot_free;

    sum_x = pos_x_q + {{(POS_BITS-STEP_BITS){step_x_q[STEP_BITS-1]}}, step_x_q};
    sum_y = pos_y_q + {{(POS_BITS-STEP_BITS){step_y_q[STEP_BITS-1]}}, step_y_q};
    ux    = {1'b0, div_rsp_i.quo_x};
    uy    = {1'b0, div_rsp_i.quo_y};

    state_d     = state_q;
    active_d    = active_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    step_x_d    = step_x_q;
    step_y_d    = step_y_q;
    left_d      = left_q;
    neg_x_d     = neg_x_q;
    neg_y_d     = neg_y_q;

    div_req_o.start = 1'b0;
    div_req_o.mag_x = cmd_i.mag_x;
    div_req_o.mag_y = cmd_i.mag_y;
    div_req_o.steps = cmd_i.steps;

    case (state_q)
      ST_RUN: begin
        if (pop) begin
          case (cmd_i.op)
            OP_START: begin
              pos_x_d          = {cmd_i.org_x, {FRAC_BITS{1'b0}}};
              pos_y_d          = {cmd_i.org_y, {FRAC_BITS{1'b0}}};
              left_d           = {1'b0, cmd_i.steps};
              neg_x_d          = cmd_i.neg_x;
              neg_y_d          = cmd_i.neg_y;
              active_d         = 1'b0;
              out_d.pixel_x    = cmd_i.org_x;
              out_d.pixel_y    = cmd_i.org_y;
              out_d.last_pixel = (cmd_i.steps == '0);
              out_valid_d      = 1'b1;
              // Zero-length line is done with the start pixel.
              if (cmd_i.steps != '0) begin
                div_req_o.start = 1'b1;
                state_d         = ST_DIV;
              end
            end
            OP_NEXT: begin
              if (active_q) begin
                pos_x_d          = sum_x;
                pos_y_d          = sum_y;
                left_d           = left_q - 1'b1;
                active_d         = (left_q != LEFT_BITS'(1));
                out_d.pixel_x    = pixel_of(sum_x);
                out_d.pixel_y    = pixel_of(sum_y);
                out_d.last_pixel = (left_q == LEFT_BITS'(1));
                out_valid_d      = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_rsp_i.done) begin
          step_x_d = neg_x_q ? STEP_BITS'(0) - ux : ux;
          step_y_d = neg_y_q ? STEP_BITS'(0) - uy : uy;
          active_d = 1'b1;
          state_d  = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    pos_x_q  <= pos_x_d;
    pos_y_q  <= pos_y_d;
    step_x_q <= step_x_d;
    step_y_q <= step_y_d;
    left_q   <= left_d;
    neg_x_q  <= neg_x_d;
    neg_y_q  <= neg_y_d;
  end

  assign pop_o       = pop;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

[sv/dda_line_generator.sv]
// DDA line generator top level: front end, command queue, back end, divider.
// An accepted transaction is written to the command queue; the back end pops it into the
// output register once it is in its run state and the output slot is free.
// Throughput: next-pixel transactions go at 1 per cycle while the output is not stalled; a
// start holds the back end in its divide state while the shared restoring divider forms one quotient bit a cycle.
// The 2-entry queue keeps taking transactions while the back end divides, until it is full.
// Reset (rst_ni low, asynchronous) empties the queue, drops any active line, clears output.
`timescale 1ns / 1ps
`default_nettype none
module dda_line_generator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dda_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dda_pkg::out_item_t out_item_o
);
  import dda_pkg::*;

  logic     push;
  logic     full;
  logic     pop;
  logic     cmd_valid;
  cmd_t     cmd_in;
  cmd_t     cmd_out;
  div_req_t div_req;
  div_rsp_t div_rsp;

  dda_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  dda_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  dda_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  dda_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

[sv/dda_checker.sv]
// Port-level checker for the DDA line generator, bound to the top level.
// Depends on dda_pkg and dda_line_generator_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "dda_line_generator_defines.svh"
module dda_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input dda_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input dda_pkg::out_item_t out_item_o
);
  import dda_pkg::*;

  logic in_xact;
  assign in_xact = in_valid_i && !in_stall_o;

  `DDA_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `DDA_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_item_o))
  // The queue only fills through an accepted transaction.
  `DDA_ASSERT_IMP(a_stall_cause, $rose(in_stall_o), $past(in_xact))
  `DDA_ASSERT_IMP(a_reset_clean, $rose(rst_ni), !out_valid_o && !in_stall_o)

endmodule

bind dda_line_generator dda_checker u_dda_checker (.*);
`default_nettype wire

[sim/dda_line_checker.sv]
// Checker of the DDA line generator: watches both channels, predicts each pixel
// and compares it field by field. Depends on dda_pkg for the transaction types.
`timescale 1ns / 1ps
module dda_line_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  dda_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  dda_pkg::out_item_t out_item_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import dda_pkg::*;

  // Own copy of the line state, at the block's widths.
  logic signed [POS_BITS-1:0]  pos_x, pos_y;
  logic signed [STEP_BITS-1:0] step_x, step_y;
  logic        [LEFT_BITS-1:0] pixels_left;
  logic                        line_active;

  out_item_t pixels_due[$];
  out_item_t px_new, px_due;
  int        fails;

  // Integer part of a fixed-point position, rounded toward zero.
  function automatic logic [COORD_BITS-1:0] whole_part(input logic signed [POS_BITS-1:0] p);
    longint q;
    q = longint'(p) / (longint'(1) <<< FRAC_BITS);
    return q[COORD_BITS-1:0];
  endfunction

  // Advances the line for one transaction; returns 1 when a pixel comes out.
  function automatic bit trace_pixel(input in_item_t it, output out_item_t px);
    longint sx, sy, dx, dy, ax, ay, steps, one;
    px = '0;
    one = longint'(1) <<< FRAC_BITS;
    if (it.mode == OP_START) begin
      sx = $signed(it.start_x);
      sy = $signed(it.start_y);
      dx = longint'($signed(it.end_x)) - sx;
      dy = longint'($signed(it.end_y)) - sy;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      steps = ax > ay ? ax : ay;
      pos_x = POS_BITS'(sx * one);
      pos_y = POS_BITS'(sy * one);
      if (steps > 0) begin
        step_x = STEP_BITS'((dx * one) / steps);
        step_y = STEP_BITS'((dy * one) / steps);
      end else begin
        step_x = '0;
        step_y = '0;
      end
      pixels_left = LEFT_BITS'(steps);
      line_active = steps > 0;
      px.pixel_x = whole_part(pos_x);
      px.pixel_y = whole_part(pos_y);
      px.last_pixel = steps == 0;
      return 1'b1;
    end
    if (!line_active) begin
      return 1'b0;
    end
    pos_x = pos_x + step_x;
    pos_y = pos_y + step_y;
    pixels_left = pixels_left - 1'b1;
    line_active = pixels_left != '0;
    px.pixel_x = whole_part(pos_x);
    px.pixel_y = whole_part(pos_y);
    px.last_pixel = !line_active;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x = '0;
      pos_y = '0;
      step_x = '0;
      step_y = '0;
      pixels_left = '0;
      line_active = 1'b0;
      pixels_due.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (trace_pixel(in_item_i, px_new)) begin
          pixels_due.push_back(px_new);
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (pixels_due.size() == 0) begin
          $error("unexpected pixel transaction: x %0d y %0d last %0d",
                 $signed(out_item_i.pixel_x), $signed(out_item_i.pixel_y),
                 out_item_i.last_pixel);
          fails++;
        end else begin
          px_due = pixels_due.pop_front();
          check_field("pixel_x", $signed(px_due.pixel_x), $signed(out_item_i.pixel_x));
          check_field("pixel_y", $signed(px_due.pixel_y), $signed(out_item_i.pixel_y));
          check_field("last_pixel", px_due.last_pixel, out_item_i.last_pixel);
        end
      end
      fail_count_o <= fails;
      pending_o <= pixels_due.size();
    end
  end

endmodule

[sim/tb_dda_line_generator.sv]
// Testbench top of the DDA line generator: clock, reset, line stimulus, stalls,
// watchdog and verdict. Depends on dda_pkg, dda_line_generator and dda_line_checker.
`timescale 1ns / 1ps
module tb_dda_line_generator;
  import dda_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1950;
  localparam int DRAIN_CYCLES = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        cyc = 0;
  int        idle_cycles = 0;
  logic      calm;

  always #5 clk = ~clk;

  dda_line_generator u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  dda_line_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Window of cycles with no idling on either side.
  assign calm = (cyc >= 2000) && (cyc < 3500);

  always @(posedge clk) begin
    cyc <= cyc + 1;
    out_stall <= !calm && ($urandom_range(99) < 16);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic int rand_coord();
    return int'($urandom_range(4095)) - 2048;
  endfunction

  // Random coordinate within d of c, kept inside the signed 12-bit range.
  function automatic int rand_near(input int c, input int d);
    int lo, hi;
    lo = (c - d < -2048) ? -2048 : c - d;
    hi = (c + d > 2047) ? 2047 : c + d;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int line_steps(input int sx, input int sy, input int ex, input int ey);
    int ax, ay;
    ax = (ex > sx) ? ex - sx : sx - ex;
    ay = (ey > sy) ? ey - sy : sy - ey;
    return (ax > ay) ? ax : ay;
  endfunction

  task automatic send(input logic mode, input int sx, input int sy, input int ex,
                      input int ey);
    in_item_t it;
    it.mode = mode;
    it.start_x = COORD_BITS'(sx);
    it.start_y = COORD_BITS'(sy);
    it.end_x = COORD_BITS'(ex);
    it.end_y = COORD_BITS'(ey);
    while (!calm && ($urandom_range(99) < 16)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Start a line, then request walk more pixels with junk in the coordinate fields.
  task automatic run_line(input int sx, input int sy, input int ex, input int ey,
                          input int walk);
    send(OP_START, sx, sy, ex, ey);
    repeat (walk) send(OP_NEXT, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  initial begin
    int sx, sy, ex, ey, walk, pick, sent, extra;
    sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: no line, zero-length lines, full-range diagonals, restart mid-line,
    // negative slopes past the end.
    send(OP_NEXT, 2047, -2048, 2047, -2048);
    run_line(0, 0, 0, 0, 1);
    run_line(-2048, 2047, -2048, 2047, 0);
    run_line(-2048, -2048, 2047, 2047, 3);
    run_line(2047, -2048, -2048, 2047, 2);
    run_line(0, 0, -3, -7, 8);
    run_line(-1, 1, 2, -1, 3);

    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      sx = rand_coord();
      sy = rand_coord();
      if (pick < 92) begin
        if (pick < 65) begin
          ex = rand_near(sx, 16);
          ey = rand_near(sy, 16);
          walk = line_steps(sx, sy, ex, ey) + (($urandom_range(4) == 0) ? 1 : 0);
        end else if (pick < 77) begin
          ex = rand_near(sx, 200);
          ey = rand_near(sy, 200);
          walk = line_steps(sx, sy, ex, ey);
        end else if (pick < 87) begin
          // long line, abandoned early by the next start
          ex = rand_coord();
          ey = rand_coord();
          walk = $urandom_range(20);
        end else begin
          ex = sx;
          ey = sy;
          walk = 0;
        end
        run_line(sx, sy, ex, ey, walk);
        sent += walk + 1;
      end else begin
        extra = $urandom_range(3, 1);
        repeat (extra) send(OP_NEXT, sx, sy, rand_coord(), rand_coord());
        sent += extra;
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
